// ===== rtl/ptzfb_pkg.sv =====
// Package: command codes, register indexes, frame constants and speed tables.
package ptzfb_pkg;

    localparam int unsigned FRAME_LEN = 11;
    localparam int unsigned CNT_W     = $clog2(FRAME_LEN);

    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LEN - 1);

    localparam logic [7:0] START_CODE = 8'hA0;
    localparam logic [7:0] END_CODE   = 8'hAF;

    // Frame byte positions.
    typedef enum logic [CNT_W-1:0] {
        POS_START = 4'd0,
        POS_ADDR  = 4'd1,
        POS_HOST  = 4'd2,
        POS_C0    = 4'd3,
        POS_C1    = 4'd4,
        POS_C2    = 4'd5,
        POS_C3    = 4'd6,
        POS_C4    = 4'd7,
        POS_PAD   = 4'd8,
        POS_END   = 4'd9,
        POS_CHK   = 4'd10
    } pos_t;

    typedef enum logic [4:0] {
        KIND_PAN_LEFT    = 5'd0,
        KIND_PAN_RIGHT   = 5'd1,
        KIND_TILT_UP     = 5'd2,
        KIND_TILT_DOWN   = 5'd3,
        KIND_LEFT_UP     = 5'd4,
        KIND_LEFT_DOWN   = 5'd5,
        KIND_RIGHT_UP    = 5'd6,
        KIND_RIGHT_DOWN  = 5'd7,
        KIND_ZOOM_TELE   = 5'd8,
        KIND_ZOOM_WIDE   = 5'd9,
        KIND_IRIS_OPEN   = 5'd10,
        KIND_IRIS_CLOSE  = 5'd11,
        KIND_FOCUS_FAR   = 5'd12,
        KIND_FOCUS_NEAR  = 5'd13,
        KIND_STOP        = 5'd14,
        KIND_SET_PRESET  = 5'd15,
        KIND_GOTO_PRESET = 5'd16
    } kind_t;

    typedef enum logic [1:0] {
        REG_DOME_ADDRESS  = 2'd0,
        REG_PANTILT_SPEED = 2'd1,
        REG_FOCUS_SPEED   = 2'd2,
        REG_ZOOM_SPEED    = 2'd3
    } reg_idx_t;

    // Variable part of one frame: address, command bytes c0..c4, checksum.
    typedef struct packed {
        logic [7:0]      addr;
        logic [4:0][7:0] cmd;
        logic [7:0]      chk;
    } frame_t;

    // (v/10 - 1) saturated to 0..9, done as threshold compares.
    function automatic logic [3:0] speed_index(input logic [7:0] v);
        logic [3:0] idx;
        if (v < 8'd20)       idx = 4'd0;
        else if (v < 8'd30)  idx = 4'd1;
        else if (v < 8'd40)  idx = 4'd2;
        else if (v < 8'd50)  idx = 4'd3;
        else if (v < 8'd60)  idx = 4'd4;
        else if (v < 8'd70)  idx = 4'd5;
        else if (v < 8'd80)  idx = 4'd6;
        else if (v < 8'd90)  idx = 4'd7;
        else if (v < 8'd100) idx = 4'd8;
        else                 idx = 4'd9;
        return idx;
    endfunction

    function automatic logic [7:0] pt_speed(input logic [3:0] idx);
        logic [7:0] s;
        unique case (idx)
            4'd0:    s = 8'h14;
            4'd1:    s = 8'h1A;
            4'd2:    s = 8'h20;
            4'd3:    s = 8'h26;
            4'd4:    s = 8'h2C;
            4'd5:    s = 8'h2F;
            4'd6:    s = 8'h35;
            4'd7:    s = 8'h3A;
            4'd8:    s = 8'h3D;
            4'd9:    s = 8'h40;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] zf_speed(input logic [3:0] idx);
        logic [7:0] s;
        unique case (idx)
            4'd0:    s = 8'h01;
            4'd1:    s = 8'h02;
            4'd2:    s = 8'h02;
            4'd3:    s = 8'h03;
            4'd4:    s = 8'h04;
            4'd5:    s = 8'h04;
            4'd6:    s = 8'h05;
            4'd7:    s = 8'h06;
            4'd8:    s = 8'h07;
            4'd9:    s = 8'h08;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/ptz_command_frame_builder.sv =====
// PTZ command frame builder: one command in, an eleven-byte control frame out.
//
//  channel  | ports                                   | beat
//  ---------+-----------------------------------------+------------------------------
//  input    | s_valid s_ready s_kind s_param_value    | one command
//  result   | m_valid m_ready m_frame_byte m_last_byte| one frame byte, last = checksum
//  config   | cfg_we cfg_index cfg_wdata              | one register write
//
// A command is built into a frame register in the cycle it is accepted
// (speed lookup, command bytes, checksum), then handed to the byte
// serializer, which sends 11 beats, one per cycle while m_ready is high.
// The frame register takes the next command while the current frame streams,
// so back-to-back frames come out with no gap.
// Reset (aresetn low, synchronous) empties both stages and loads the register
// defaults: address 1, all default speeds 50.
// A low m_ready holds the current byte; input stalls once the frame register
// is full and the serializer busy.
module ptz_command_frame_builder
    import ptzfb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // config
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    // command beat
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [4:0] s_kind,
    input  logic [7:0] s_param_value,
    // frame byte beat
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_frame_byte,
    output logic       m_last_byte
);

    // ---------------- configuration registers ----------------
    logic [7:0] dome_addr_reg;
    logic [7:0] pt_pct_reg;
    logic [7:0] focus_pct_reg;
    logic [7:0] zoom_pct_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dome_addr_reg <= 8'd1;
            pt_pct_reg    <= 8'd50;
            focus_pct_reg <= 8'd50;
            zoom_pct_reg  <= 8'd50;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_DOME_ADDRESS:  dome_addr_reg <= cfg_wdata;
                REG_PANTILT_SPEED: pt_pct_reg    <= cfg_wdata;
                REG_FOCUS_SPEED:   focus_pct_reg <= cfg_wdata;
                REG_ZOOM_SPEED:    zoom_pct_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- frame build (combinational) ----------------
    kind_t      kind;
    logic       param_nz;
    logic       is_pantilt;   // pan/tilt kinds that use the default speed
    logic       is_focus;
    logic       is_zoom;
    logic [7:0] speed_src;
    logic [3:0] spd_idx;
    logic [7:0] pt;
    logic [7:0] zf;
    frame_t     built;
    logic [7:0] sum;

    always_comb begin
        kind       = kind_t'(s_kind);
        param_nz   = (s_param_value != 8'd0);
        is_pantilt = (kind == KIND_PAN_LEFT) || (kind == KIND_PAN_RIGHT) ||
                     (kind == KIND_TILT_UP)  || (kind == KIND_TILT_DOWN);
        is_focus   = (kind == KIND_FOCUS_FAR) || (kind == KIND_FOCUS_NEAR);
        is_zoom    = (kind == KIND_ZOOM_TELE) || (kind == KIND_ZOOM_WIDE);

        // One table index serves both tables: the nonzero parameter,
        // else the class default.
        priority if (param_nz) speed_src = s_param_value;
        else if (is_pantilt)   speed_src = pt_pct_reg;
        else if (is_focus)     speed_src = focus_pct_reg;
        else                   speed_src = zoom_pct_reg;

        spd_idx = speed_index(speed_src);
        pt      = (param_nz || is_pantilt)           ? pt_speed(spd_idx) : 8'h00;
        zf      = (param_nz || is_focus || is_zoom)  ? zf_speed(spd_idx) : 8'h00;

        built      = '0;
        built.addr = dome_addr_reg;
        unique case (kind)
            KIND_PAN_LEFT:    begin built.cmd[1] = 8'h04; built.cmd[2] = pt; end
            KIND_PAN_RIGHT:   begin built.cmd[1] = 8'h02; built.cmd[2] = pt; end
            KIND_TILT_UP:     begin built.cmd[1] = 8'h08; built.cmd[3] = pt; end
            KIND_TILT_DOWN:   begin built.cmd[1] = 8'h10; built.cmd[3] = pt; end
            KIND_LEFT_UP:     begin
                built.cmd[1] = 8'h0C; built.cmd[2] = pt; built.cmd[3] = pt;
            end
            KIND_LEFT_DOWN:   begin
                built.cmd[1] = 8'h14; built.cmd[2] = pt; built.cmd[3] = pt;
            end
            KIND_RIGHT_UP:    begin
                built.cmd[1] = 8'h0A; built.cmd[2] = pt; built.cmd[3] = pt;
            end
            KIND_RIGHT_DOWN:  begin
                built.cmd[1] = 8'h12; built.cmd[2] = pt; built.cmd[3] = pt;
            end
            KIND_ZOOM_TELE:   begin built.cmd[1] = 8'h20; built.cmd[4] = zf; end
            KIND_ZOOM_WIDE:   begin
                built.cmd[0] = 8'h01; built.cmd[1] = 8'h40; built.cmd[4] = zf;
            end
            KIND_IRIS_OPEN:   begin built.cmd[0] = 8'h01; built.cmd[1] = 8'h08; end
            KIND_IRIS_CLOSE:  begin built.cmd[0] = 8'h01; built.cmd[1] = 8'h10; end
            KIND_FOCUS_FAR:   begin built.cmd[0] = 8'h01; built.cmd[4] = zf; end
            KIND_FOCUS_NEAR:  begin built.cmd[0] = 8'h02; built.cmd[4] = zf; end
            KIND_SET_PRESET:  begin built.cmd[1] = 8'h03; built.cmd[2] = s_param_value; end
            KIND_GOTO_PRESET: begin built.cmd[1] = 8'h07; built.cmd[2] = s_param_value; end
            // stop and undefined codes: all command bytes zero
            default: ;
        endcase

        // host and pad bytes are zero, so they drop out of the sum
        sum = built.addr + built.cmd[0] + built.cmd[1] + built.cmd[2] +
              built.cmd[3] + built.cmd[4];
        built.chk = ~sum;
    end

    // ---------------- frame register ----------------
    frame_t hold_reg;
    logic   hold_valid_reg;
    logic   hold_valid_next;

    // ---------------- serializer ----------------
    frame_t           ser_reg;
    logic             ser_valid_reg;
    logic             ser_valid_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic s_fire;
    logic m_fire;
    logic ser_load;

    assign m_fire   = m_valid && m_ready;
    assign ser_load = hold_valid_reg && (!ser_valid_reg || (m_fire && m_last_byte));
    assign s_ready  = !hold_valid_reg || ser_load;
    assign s_fire   = s_valid && s_ready;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (s_fire)        hold_valid_next = 1'b1;
        else if (ser_load) hold_valid_next = 1'b0;

        ser_valid_next = ser_valid_reg;
        cnt_next       = cnt_reg;
        if (ser_load) begin
            ser_valid_next = 1'b1;
            cnt_next       = '0;
        end else if (m_fire) begin
            if (m_last_byte) begin
                ser_valid_next = 1'b0;
                cnt_next       = '0;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            ser_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            ser_valid_reg  <= ser_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_fire)   hold_reg <= built;
        if (ser_load) ser_reg  <= hold_reg;
    end

    // ---------------- output byte select ----------------
    always_comb begin
        unique case (pos_t'(cnt_reg))
            POS_START: m_frame_byte = START_CODE;
            POS_ADDR:  m_frame_byte = ser_reg.addr;
            POS_HOST:  m_frame_byte = 8'h00;
            POS_C0:    m_frame_byte = ser_reg.cmd[0];
            POS_C1:    m_frame_byte = ser_reg.cmd[1];
            POS_C2:    m_frame_byte = ser_reg.cmd[2];
            POS_C3:    m_frame_byte = ser_reg.cmd[3];
            POS_C4:    m_frame_byte = ser_reg.cmd[4];
            POS_PAD:   m_frame_byte = 8'h00;
            POS_END:   m_frame_byte = END_CODE;
            POS_CHK:   m_frame_byte = ser_reg.chk;
            default:   m_frame_byte = 8'h00;
        endcase
    end

    assign m_valid     = ser_valid_reg;
    assign m_last_byte = ser_valid_reg && (cnt_reg == LAST_POS);

endmodule

// ===== rtl/ptzfb_checker.sv =====
// Port-level checker for the PTZ command frame builder, with its bind.
module ptzfb_checker
    import ptzfb_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_frame_byte,
    input logic       m_last_byte
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_frame_byte) &&
                                   $stable(m_last_byte)))
        else $error("result beat changed while stalled");

    // a frame once started streams on without a bubble
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_byte) |=> m_valid)
        else $error("gap inside a frame");

    // the beat after a checksum, if any, opens a new frame
    a_next_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_byte) |=> (!m_valid || m_frame_byte == START_CODE))
        else $error("frame does not open with start code");

    // last flag only on a live beat
    a_last_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_last_byte |-> m_valid)
        else $error("last flag without valid");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind ptz_command_frame_builder ptzfb_checker u_ptzfb_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_frame_byte (m_frame_byte),
    .m_last_byte  (m_last_byte)
);

// ===== tb/sv/tb_ptz_command_frame_builder.sv =====
// Testbench for ptz_command_frame_builder: directed and random commands checked beat by beat.
`timescale 1ns / 100ps

module tb_ptz_command_frame_builder;
    import ptzfb_pkg::*;

    // Kinds past the last defined command; the block must treat them like stop.
    localparam logic [4:0] UNKNOWN_LO = 5'd17;
    localparam logic [4:0] UNKNOWN_HI = 5'd31;

    // Speed steps by index, element 0 is the rightmost entry.
    localparam logic [9:0][7:0] PT_STEPS = {
        8'h40, 8'h3d, 8'h3a, 8'h35, 8'h2f, 8'h2c, 8'h26, 8'h20, 8'h1a, 8'h14
    };
    localparam logic [9:0][7:0] ZF_STEPS = {
        8'h08, 8'h07, 8'h06, 8'h05, 8'h04, 8'h04, 8'h03, 8'h02, 8'h02, 8'h01
    };

    // One expected frame byte beat.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_beat_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic [4:0] s_kind;
    logic [7:0] s_param_value;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_frame_byte;
    logic       m_last_byte;

    // Shadow copy of the four registers, updated with every write.
    logic [7:0] dome_cfg;
    logic [7:0] pantilt_cfg;
    logic [7:0] focus_cfg;
    logic [7:0] zoom_cfg;

    frame_beat_t pending_beats[$];  // frame bytes still owed by the block
    frame_beat_t head_beat;
    int unsigned fail_count;
    bit          idle_on;           // random idling on both channels

    ptz_command_frame_builder uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_param_value (s_param_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_frame_byte  (m_frame_byte),
        .m_last_byte   (m_last_byte)
    );

    // 2 ns clock.
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame prediction
    // ------------------------------------------------------------------

    // Percent to table index: v/10 - 1, clamped to 0..9.
    function automatic int unsigned step_index(input logic [7:0] v);
        int unsigned q;
        q = v / 10;
        if (q == 0) begin
            return 0;
        end
        q = q - 1;
        return (q > 9) ? 9 : q;
    endfunction

    // Builds the eleven bytes of one command frame and queues them.
    function automatic void predict_frame(input logic [4:0] kind, input logic [7:0] param);
        logic [7:0] f [FRAME_LEN];
        logic [7:0] pt;
        logic [7:0] zf;
        logic [7:0] sum;
        frame_beat_t b;
        int i;
        pt = 8'h00;
        zf = 8'h00;
        for (i = 0; i < FRAME_LEN; i++) begin
            f[i] = 8'h00;
        end
        // A nonzero parameter sets both speeds; a zero one only the class default.
        // Diagonals with a zero parameter get no speed at all.
        if (param != 8'h00) begin
            pt = PT_STEPS[step_index(param)];
            zf = ZF_STEPS[step_index(param)];
        end else if (kind <= KIND_TILT_DOWN) begin
            pt = PT_STEPS[step_index(pantilt_cfg)];
        end else if (kind == KIND_FOCUS_FAR || kind == KIND_FOCUS_NEAR) begin
            zf = ZF_STEPS[step_index(focus_cfg)];
        end else if (kind == KIND_ZOOM_TELE || kind == KIND_ZOOM_WIDE) begin
            zf = ZF_STEPS[step_index(zoom_cfg)];
        end
        f[POS_START] = START_CODE;
        f[POS_ADDR]  = dome_cfg;
        case (kind)
            KIND_PAN_LEFT: begin
                f[POS_C1] = 8'h04; f[POS_C2] = pt;
            end
            KIND_PAN_RIGHT: begin
                f[POS_C1] = 8'h02; f[POS_C2] = pt;
            end
            KIND_TILT_UP: begin
                f[POS_C1] = 8'h08; f[POS_C3] = pt;
            end
            KIND_TILT_DOWN: begin
                f[POS_C1] = 8'h10; f[POS_C3] = pt;
            end
            KIND_LEFT_UP: begin
                f[POS_C1] = 8'h0c; f[POS_C2] = pt; f[POS_C3] = pt;
            end
            KIND_LEFT_DOWN: begin
                f[POS_C1] = 8'h14; f[POS_C2] = pt; f[POS_C3] = pt;
            end
            KIND_RIGHT_UP: begin
                f[POS_C1] = 8'h0a; f[POS_C2] = pt; f[POS_C3] = pt;
            end
            KIND_RIGHT_DOWN: begin
                f[POS_C1] = 8'h12; f[POS_C2] = pt; f[POS_C3] = pt;
            end
            KIND_ZOOM_TELE: begin
                f[POS_C1] = 8'h20; f[POS_C4] = zf;
            end
            KIND_ZOOM_WIDE: begin
                f[POS_C0] = 8'h01; f[POS_C1] = 8'h40; f[POS_C4] = zf;
            end
            KIND_IRIS_OPEN: begin
                f[POS_C0] = 8'h01; f[POS_C1] = 8'h08;
            end
            KIND_IRIS_CLOSE: begin
                f[POS_C0] = 8'h01; f[POS_C1] = 8'h10;
            end
            KIND_FOCUS_FAR: begin
                f[POS_C0] = 8'h01; f[POS_C4] = zf;
            end
            KIND_FOCUS_NEAR: begin
                f[POS_C0] = 8'h02; f[POS_C4] = zf;
            end
            // presets carry the raw parameter, zero included
            KIND_SET_PRESET: begin
                f[POS_C1] = 8'h03; f[POS_C2] = param;
            end
            KIND_GOTO_PRESET: begin
                f[POS_C1] = 8'h07; f[POS_C2] = param;
            end
            default: begin
                // stop and unknown kinds: all command bytes zero
            end
        endcase
        f[POS_END] = END_CODE;
        sum = 8'h00;
        for (i = POS_ADDR; i <= POS_PAD; i++) begin
            sum = sum + f[i];
        end
        f[POS_CHK] = ~sum;
        for (i = 0; i < FRAME_LEN; i++) begin
            b.data = f[i];
            b.last = (i == POS_CHK);
            pending_beats.push_back(b);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking: every accepted beat against the oldest expected byte
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_beats.size() == 0) begin
                $error("unexpected beat: frame_byte %02h last_byte %0b",
                       m_frame_byte, m_last_byte);
                fail_count++;
            end else begin
                head_beat = pending_beats.pop_front();
                if (m_frame_byte !== head_beat.data) begin
                    $error("frame_byte: expected %02h, actual %02h",
                           head_beat.data, m_frame_byte);
                    fail_count++;
                end
                if (m_last_byte !== head_beat.last) begin
                    $error("last_byte: expected %0b, actual %0b",
                           head_beat.last, m_last_byte);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: m_ready drops low in random bursts
    // ------------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One command beat; returns right after the accepting edge with valid still high,
    // so the next call can follow without a bubble.
    task automatic send_cmd(input logic [4:0] kind, input logic [7:0] param);
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_param_value <= param;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_frame(kind, param);
    endtask

    // Input gap with valid low; n sets its length.
    task automatic pause_input(input int unsigned n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    // Random input gap, only while idling is on.
    task automatic maybe_pause();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            pause_input($urandom_range(1, 8));
        end
    endtask

    // Waits until every queued frame byte has come out.
    task automatic wait_drained();
        while (pending_beats.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_DOME_ADDRESS:  dome_cfg    = val;
            REG_PANTILT_SPEED: pantilt_cfg = val;
            REG_FOCUS_SPEED:   focus_cfg   = val;
            REG_ZOOM_SPEED:    zoom_cfg    = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Register writes only once the block has gone idle.
    task automatic apply_settings(input logic [7:0] dome, input logic [7:0] pt,
                                  input logic [7:0] focus, input logic [7:0] zoom);
        pause_input(1);
        wait_drained();
        write_reg(REG_DOME_ADDRESS, dome);
        write_reg(REG_PANTILT_SPEED, pt);
        write_reg(REG_FOCUS_SPEED, focus);
        write_reg(REG_ZOOM_SPEED, zoom);
    endtask

    // Percent value biased toward zero and the table step edges.
    function automatic logic [7:0] pick_percent();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r < 2) begin
            return 8'd0;
        end else if (r == 2) begin
            case ($urandom_range(0, 6))
                0:       return 8'd9;
                1:       return 8'd10;
                2:       return 8'd19;
                3:       return 8'd20;
                4:       return 8'd99;
                5:       return 8'd100;
                default: return 8'd255;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly defined commands, some unknown kinds.
    task automatic send_random_cmd();
        logic [4:0] kind;
        if ($urandom_range(0, 9) == 0) begin
            kind = 5'($urandom_range(UNKNOWN_LO, UNKNOWN_HI));
        end else begin
            kind = 5'($urandom_range(KIND_PAN_LEFT, KIND_GOTO_PRESET));
        end
        maybe_pause();
        send_cmd(kind, pick_percent());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every command once with a zero parameter, using the register defaults.
    task automatic test_reset_defaults();
        int k;
        for (k = KIND_PAN_LEFT; k <= KIND_GOTO_PRESET; k++) begin
            maybe_pause();
            send_cmd(5'(k), 8'd0);
        end
    endtask

    // Parameter extremes, step edges, a set-preset at 255, unknown kinds.
    task automatic test_param_edges();
        send_cmd(KIND_PAN_LEFT, 8'd255);
        send_cmd(KIND_TILT_DOWN, 8'd9);
        send_cmd(KIND_PAN_RIGHT, 8'd10);
        send_cmd(KIND_ZOOM_TELE, 8'd99);
        send_cmd(KIND_FOCUS_NEAR, 8'd100);
        send_cmd(KIND_RIGHT_UP, 8'd1);
        send_cmd(KIND_SET_PRESET, 8'd255);
        send_cmd(UNKNOWN_HI, 8'haa);
        send_cmd(UNKNOWN_LO, 8'd0);
    endtask

    // One register setting followed by random commands.
    task automatic test_random_phase(input logic [7:0] dome, input logic [7:0] pt,
                                     input logic [7:0] focus, input logic [7:0] zoom,
                                     input int unsigned n);
        int unsigned i;
        apply_settings(dome, pt, focus, zoom);
        for (i = 0; i < n; i++) begin
            send_random_cmd();
        end
    endtask

    // Closing stretch: no idling on either side, commands back to back.
    task automatic test_back_to_back(input int unsigned n);
        int unsigned i;
        idle_on = 1'b0;
        apply_settings(pick_percent(), pick_percent(), pick_percent(), pick_percent());
        for (i = 0; i < n; i++) begin
            send_random_cmd();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_DOME_ADDRESS;
        cfg_wdata     = 8'h00;
        s_valid       = 1'b0;
        s_kind        = KIND_PAN_LEFT;
        s_param_value = 8'h00;
        fail_count    = 0;
        idle_on       = 1'b1;
        // register defaults after reset
        dome_cfg      = 8'd1;
        pantilt_cfg   = 8'd50;
        focus_cfg     = 8'd50;
        zoom_cfg      = 8'd50;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_param_edges();
        // all-zero and all-ones registers, then step edges, then random
        test_random_phase(8'h00, 8'h00, 8'h00, 8'h00, 15);
        test_random_phase(8'hff, 8'hff, 8'hff, 8'hff, 15);
        test_random_phase(8'h5a, 8'd9, 8'd10, 8'd100, 15);
        test_random_phase(8'($urandom_range(0, 255)), pick_percent(),
                          pick_percent(), pick_percent(), 15);
        test_random_phase(8'($urandom_range(0, 255)), pick_percent(),
                          pick_percent(), pick_percent(), 15);
        test_back_to_back(20);

        pause_input(1);
        wait_drained();
        // room for any stray beat
        repeat (30) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hang guard, far past the slowest legal run.
    initial begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
